// ===== rtl/core/txc_pkg.sv =====
// Package for the text console writer: geometry constants, command codes and word types.
// Used by txc_ctrl and text_console_writer; it depends on nothing.
package txc_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 50;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  localparam int CELL_W  = 16;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int OFF_W   = 12;
  localparam int FUNC_W  = 3;

  localparam logic [FUNC_W-1:0] FN_PUT_CUR = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUT_POS = 3'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SET_CUR = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ    = 3'd4;

  localparam logic [CELL_W-1:0] FILL_RESET = 16'h0F20;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [7:0]        color;
    logic [7:0]        character;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } in_word_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [OFF_W-1:0]  cursor_offset;
    logic              status;
  } out_word_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/core/txc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; depends on nothing.
module txc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/txc_ctrl.sv =====
// Command sequencer of the text console: cursor registers, command decode,
// and the copy/fill walks over the cell store. Depends on txc_pkg.
module txc_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  txc_pkg::in_word_t          in_word_i,
  input  logic [txc_pkg::CELL_W-1:0] fill_code_i,
  input  logic [txc_pkg::CELL_W-1:0] rdata_i,
  output txc_pkg::mem_req_t          mem_o,
  output logic                       busy_o,
  output logic                       res_valid_o,
  output txc_pkg::out_word_t         res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;
  localparam logic [1:0] ST_FILL = 2'd3;

  localparam int AW = txc_pkg::ADDR_W;
  localparam logic [AW-1:0] LAST_CELL     = AW'(txc_pkg::CELLS - 1);
  localparam logic [AW-1:0] LAST_COPY     = AW'(txc_pkg::CELLS - txc_pkg::COLUMNS - 1);
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'((txc_pkg::ROWS - 1) * txc_pkg::COLUMNS);

  logic [1:0]                 state_q, state_d;
  logic [txc_pkg::COL_W-1:0]  cur_col_q, cur_col_d;
  logic [txc_pkg::ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [AW-1:0]              cur_lin_q, cur_lin_d;
  logic [AW-1:0]              rd_q, rd_d;
  logic [AW-1:0]              wr_q, wr_d;
  logic                       wvld_q, wvld_d;
  logic                       rd_done_q, rd_done_d;

  logic          pos_ok;
  logic [AW-1:0] pos_lin;
  logic          at_row_end;
  logic          at_last_row;
  logic          rd_issue;

  assign pos_ok  = (32'(in_word_i.col) < txc_pkg::COLUMNS) &&
                   (32'(in_word_i.row) < txc_pkg::ROWS);
  assign pos_lin = AW'(32'(in_word_i.row) * txc_pkg::COLUMNS + 32'(in_word_i.col));

  assign at_row_end  = (cur_col_q == txc_pkg::COL_W'(txc_pkg::COLUMNS - 1));
  assign at_last_row = (cur_row_q == txc_pkg::ROW_W'(txc_pkg::ROWS - 1));
  assign rd_issue    = (state_q == ST_COPY) && !rd_done_q;

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    cur_lin_d   = cur_lin_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    wvld_d      = 1'b0;
    rd_done_d   = rd_done_q;
    mem_o       = '0;
    mem_o.raddr = (state_q == ST_COPY) ? rd_q : pos_lin;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.cursor_offset = txc_pkg::OFF_W'(cur_lin_q);

    case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          res_valid_o = 1'b1;
          case (in_word_i.func)
            txc_pkg::FN_PUT_CUR: begin
              mem_o.we    = 1'b1;
              mem_o.waddr = cur_lin_q;
              mem_o.wdata = {in_word_i.color, in_word_i.character};
              if (at_row_end) begin
                cur_col_d = '0;
                if (at_last_row) begin
                  // scroll: cursor parks at the start of the bottom row
                  cur_lin_d = LAST_ROW_BASE;
                  rd_d      = AW'(txc_pkg::COLUMNS);
                  wr_d      = '0;
                  rd_done_d = 1'b0;
                  state_d   = ST_COPY;
                end else begin
                  cur_row_d = cur_row_q + 1'b1;
                  cur_lin_d = cur_lin_q + 1'b1;
                end
              end else begin
                cur_col_d = cur_col_q + 1'b1;
                cur_lin_d = cur_lin_q + 1'b1;
              end
              res_o.cursor_offset = txc_pkg::OFF_W'(cur_lin_d);
            end
            txc_pkg::FN_PUT_POS: begin
              if (pos_ok) begin
                mem_o.we    = 1'b1;
                mem_o.waddr = pos_lin;
                mem_o.wdata = {in_word_i.color, in_word_i.character};
              end else begin
                res_o.status = 1'b1;
              end
            end
            txc_pkg::FN_CLEAR: begin
              cur_col_d = '0;
              cur_row_d = '0;
              cur_lin_d = '0;
              wr_d      = '0;
              state_d   = ST_FILL;
              res_o.cursor_offset = '0;
            end
            txc_pkg::FN_SET_CUR: begin
              if (pos_ok) begin
                cur_col_d = in_word_i.col;
                cur_row_d = in_word_i.row;
                cur_lin_d = pos_lin;
                res_o.cursor_offset = txc_pkg::OFF_W'(pos_lin);
              end else begin
                res_o.status = 1'b1;
              end
            end
            txc_pkg::FN_READ: begin
              if (pos_ok) begin
                // data returns from the store next cycle
                res_valid_o = 1'b0;
                state_d     = ST_READ;
              end else begin
                res_o.status = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        res_valid_o      = 1'b1;
        res_o.cell_value = rdata_i;
        state_d          = ST_IDLE;
      end
      ST_COPY: begin
        if (rd_issue) begin
          rd_d      = rd_q + 1'b1;
          rd_done_d = (rd_q == LAST_CELL);
          wvld_d    = 1'b1;
        end
        if (wvld_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = wr_q;
          mem_o.wdata = rdata_i;
          wr_d        = wr_q + 1'b1;
          if (wr_q == LAST_COPY) begin
            state_d = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = wr_q;
        mem_o.wdata = fill_code_i;
        wr_d        = wr_q + 1'b1;
        if (wr_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_col_q <= '0;
      cur_row_q <= '0;
      cur_lin_q <= '0;
      wvld_q    <= 1'b0;
      rd_done_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      cur_lin_q <= cur_lin_d;
      wvld_q    <= wvld_d;
      rd_done_q <= rd_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rd_d;
    wr_q <= wr_d;
  end

endmodule

// ===== rtl/core/text_console_writer.sv =====
// Top level of the text console writer: fill code register, cell store, output register.
// Depends on txc_pkg, txc_ram and txc_ctrl.
//
//   channel  | direction | handshake                  | word
//   ---------+-----------+----------------------------+-------------------------
//   in       | input     | in_valid_i / in_stall_o    | txc_pkg::in_word_t
//   out      | output    | out_valid_o / out_stall_i  | txc_pkg::out_word_t
//   cfg      | input     | cfg_we_i (no wait)         | cfg_wdata_i, fill code
//
// Every command but an in-range read loads its result word at the accept edge; an
// in-range read loads it in the cycle after, from the registered store read.
// A clear then fills the whole store with the fill code; a put that scrolls copies 3920
// cells up by one row and fills the bottom row with the fill code.
// No input is taken during a walk or a read. The store has no reset; cursor, fill
// code and output valid do. in_stall_o also rises while the sink stalls a held word.
module text_console_writer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  txc_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output txc_pkg::out_word_t         out_word_o,
  input  logic                       cfg_we_i,
  input  logic [txc_pkg::CELL_W-1:0] cfg_wdata_i
);

  logic [txc_pkg::CELL_W-1:0] fill_q;
  logic                       out_valid_q, out_valid_d;
  txc_pkg::out_word_t         out_q;

  logic                       accept;
  logic                       busy;
  logic                       res_valid;
  txc_pkg::out_word_t         res;
  txc_pkg::mem_req_t          mem;
  logic [txc_pkg::CELL_W-1:0] rdata;

  // Hold off input while busy or while the output word cannot drain.
  assign in_stall_o = busy || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= txc_pkg::FILL_RESET;
    end else if (cfg_we_i) begin
      fill_q <= cfg_wdata_i;
    end
  end

  txc_ram #(
    .WIDTH (txc_pkg::CELL_W),
    .DEPTH (txc_pkg::CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem.we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.wdata),
    .raddr_i (mem.raddr),
    .rdata_o (rdata)
  );

  txc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_word_i   (in_word_i),
    .fill_code_i (fill_q),
    .rdata_i     (rdata),
    .mem_o       (mem),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register: load a new word, otherwise drop the held one once taken.
  always_comb begin
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // An in-range read delivers its word in the cycle after its accept.
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_word_i.func == txc_pkg::FN_READ &&
     32'(in_word_i.col) < txc_pkg::COLUMNS && 32'(in_word_i.row) < txc_pkg::ROWS)
    |=> res_valid)
    else $error("read result not produced one cycle after accept");

  // A result without an accept in the same cycle follows an accept in the previous cycle.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !accept) |-> $past(accept))
    else $error("result word without a matching accepted word");

  // A new result never overwrites a word the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !(out_valid_q && out_stall_i))
    else $error("result overwrites a stalled output word");

  // Store writes and reported cursor positions stay inside the screen.
  a_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem.we |-> 32'(mem.waddr) < txc_pkg::CELLS) and
    (res_valid |-> 32'(res.cursor_offset) < txc_pkg::CELLS))
    else $error("store address or cursor offset beyond the screen");

endmodule
